>>> hw/rtl/rpn_pkg.sv
// rpn_pkg: shared constants, operation and status codes and types for the rpn stack calculator
// no dependencies; every other file refers to it by scoped names

package rpn_pkg;

   // stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // payload widths
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 5;
   localparam int FRAC_W   = 16;

   // operation codes, anything above FUNC_MUL is an invalid operator
   localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FEW     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   // saturation limits of a q16.16 value
   localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      sat;
   } alu_res_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] top_value;
      logic                      top_valid;
      logic [DEPTH_W-1:0]        stack_depth;
      logic                      saturated;
   } rsp_res_type;

endpackage

>>> hw/rtl/rpn_req_if.sv
// rpn_req_if: request channel, valid/ready handshake with operation code and push value
// depends on rpn_pkg

interface rpn_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [rpn_pkg::FUNC_W-1:0]                func;
   logic signed [rpn_pkg::VALUE_W-1:0]        push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

>>> hw/rtl/rpn_rsp_if.sv
// rpn_rsp_if: response channel, valid/ready handshake with status and stack view
// depends on rpn_pkg

interface rpn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rpn_pkg::STATUS_W-1:0]        status;
   logic signed [rpn_pkg::VALUE_W-1:0]  top_value;
   logic                                top_valid;
   logic [rpn_pkg::DEPTH_W-1:0]         stack_depth;
   logic                                saturated;

   modport source (output valid, output status, output top_value, output top_valid,
                   output stack_depth, output saturated, input ready);
   modport sink   (input valid, input status, input top_value, input top_valid,
                   input stack_depth, input saturated, output ready);
endinterface

>>> hw/rtl/rpn_alu.sv
// rpn_alu: saturating q16.16 add and multiply of the two top stack entries
// depends on rpn_pkg

module rpn_alu (
   input  logic signed [rpn_pkg::VALUE_W-1:0] top_val,
   input  logic signed [rpn_pkg::VALUE_W-1:0] next_val,
   input  logic                               mul_sel,
   output rpn_pkg::alu_res_type               res
);

   logic [rpn_pkg::VALUE_W:0]            sum;
   logic                                 sum_ovf;
   logic signed [2*rpn_pkg::VALUE_W-1:0] prod;
   logic [2*rpn_pkg::VALUE_W-rpn_pkg::FRAC_W-rpn_pkg::VALUE_W:0] prod_hi;
   logic                                 prod_pos_ovf;
   logic                                 prod_neg_ovf;

   // 33-bit exact sum, overflow when the two top bits differ
   assign sum     = {top_val[rpn_pkg::VALUE_W-1], top_val}
                  + {next_val[rpn_pkg::VALUE_W-1], next_val};
   assign sum_ovf = sum[rpn_pkg::VALUE_W] ^ sum[rpn_pkg::VALUE_W-1];

   // full product, arithmetic shift by the fraction width is a floor
   assign prod    = top_val * next_val;
   assign prod_hi = prod[2*rpn_pkg::VALUE_W-1 : rpn_pkg::VALUE_W+rpn_pkg::FRAC_W-1];
   assign prod_pos_ovf = !prod[2*rpn_pkg::VALUE_W-1] && (|prod_hi);
   assign prod_neg_ovf =  prod[2*rpn_pkg::VALUE_W-1] && !(&prod_hi);

   always_comb begin
      if (mul_sel) begin
         res.sat = prod_pos_ovf || prod_neg_ovf;
         if (prod_pos_ovf) begin
            res.value = rpn_pkg::Q_MAX;
         end else if (prod_neg_ovf) begin
            res.value = rpn_pkg::Q_MIN;
         end else begin
            res.value = prod[rpn_pkg::VALUE_W+rpn_pkg::FRAC_W-1 : rpn_pkg::FRAC_W];
         end
      end else begin
         res.sat = sum_ovf;
         if (sum_ovf) begin
            res.value = sum[rpn_pkg::VALUE_W] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
         end else begin
            res.value = sum[rpn_pkg::VALUE_W-1:0];
         end
      end
   end

endmodule

>>> hw/rtl/rpn_stack.sv
// rpn_stack: shifting register stack with fill count, decodes one operation per cycle
// depends on rpn_pkg and rpn_alu

module rpn_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  rpn_pkg::req_item_type item,
   output rpn_pkg::rsp_res_type  res
);

   // entry 0 is the top of the stack, entries below the count are live
   logic signed [rpn_pkg::VALUE_W-1:0] entry_ff [rpn_pkg::STACK_DEPTH];
   logic signed [rpn_pkg::VALUE_W-1:0] entry_in [rpn_pkg::STACK_DEPTH];
   logic [rpn_pkg::CNT_W-1:0]          count_ff;
   logic [rpn_pkg::CNT_W-1:0]          count_in;

   rpn_pkg::alu_res_type          alu_res;
   logic [rpn_pkg::STATUS_W-1:0]  step_status;
   logic                          do_push;
   logic                          do_pop;
   logic                          do_op;
   logic                          is_full;
   logic                          is_empty;
   logic                          few_ops;

   rpn_alu u_alu (
      .top_val  (entry_ff[0]),
      .next_val (entry_ff[1]),
      .mul_sel  (item.func == rpn_pkg::FUNC_MUL),
      .res      (alu_res)
   );

   assign is_full  = (count_ff == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
   assign is_empty = (count_ff == '0);
   assign few_ops  = (count_ff < rpn_pkg::CNT_W'(2));

   always_comb begin
      do_push     = 1'b0;
      do_pop      = 1'b0;
      do_op       = 1'b0;
      step_status = rpn_pkg::ST_OK;
      unique case (item.func) inside
         rpn_pkg::FUNC_PUSH: begin
            if (is_full) step_status = rpn_pkg::ST_FULL;
            else         do_push     = 1'b1;
         end
         rpn_pkg::FUNC_POP: begin
            if (is_empty) step_status = rpn_pkg::ST_EMPTY;
            else          do_pop      = 1'b1;
         end
         rpn_pkg::FUNC_ADD, rpn_pkg::FUNC_MUL: begin
            if (few_ops) step_status = rpn_pkg::ST_FEW;
            else         do_op       = 1'b1;
         end
         default: step_status = rpn_pkg::ST_INVALID;
      endcase
   end

   // next stack contents, each entry looks only at its neighbours
   always_comb begin
      for (int i = 0; i < rpn_pkg::STACK_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (do_push) begin
            entry_in[i] = (i == 0) ? item.push_value : entry_ff[(i == 0) ? 0 : i-1];
         end else if (do_pop || do_op) begin
            if (i < rpn_pkg::STACK_DEPTH-1) begin
               entry_in[i] = entry_ff[(i < rpn_pkg::STACK_DEPTH-1) ? i+1 : i];
            end
         end
      end
      if (do_op) begin
         entry_in[0] = alu_res.value;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + rpn_pkg::CNT_W'(1);
      end else if (do_pop || do_op) begin
         count_in = count_ff - rpn_pkg::CNT_W'(1);
      end
   end

   assign res.status      = step_status;
   assign res.top_valid   = (count_in != '0);
   assign res.top_value   = res.top_valid ? entry_in[0] : '0;
   assign res.stack_depth = rpn_pkg::DEPTH_W'(count_in);
   assign res.saturated   = do_op && alu_res.sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < rpn_pkg::STACK_DEPTH; i++) begin
            entry_ff[i] <= entry_in[i];
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      step && (res.status != rpn_pkg::ST_OK) |=> count_ff == $past(count_ff))
      else $error("refused operation changed the stack count");

   a_sat_only_arith: assert property (@(posedge clock) disable iff (reset)
      step && res.saturated |->
         (item.func == rpn_pkg::FUNC_ADD || item.func == rpn_pkg::FUNC_MUL))
      else $error("saturation flagged on a non-arithmetic operation");

   a_top_valid_tracks_count: assert property (@(posedge clock) disable iff (reset)
      step |=> (count_ff != '0) == $past(res.top_valid))
      else $error("top valid disagrees with stack count");

endmodule

>>> hw/rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: an accepted request waits in the input register, is executed by
// the stack, and its response is held in the response register until taken
// one request per cycle while the consumer keeps up: stack and count update in a single
// execute stage that feeds back to itself, with the 32x32 multiply in that stage
// reset clears the input and response valid flags and the stack count;
// stack entries are not reset and are only read below the count
// depends on rpn_pkg, rpn_req_if, rpn_rsp_if, rpn_stack

module rpn_stack_calculator (
   input  logic           clock,
   input  logic           reset,
   rpn_req_if.sink        req_ch,
   rpn_rsp_if.source      rsp_ch
);

   // input register, holds one accepted request
   logic                  in_valid_ff;
   logic                  in_valid_in;
   rpn_pkg::req_item_type in_item_ff;

   // response register, parts the execute stage from the consumer
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rpn_pkg::rsp_res_type  out_res_ff;

   rpn_pkg::rsp_res_type  step_res;
   logic                  advance;
   logic                  req_take;

   // execute when a request waits and the response slot is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   // accept a new request when none is held or the held one moves on this cycle
   assign req_ch.ready = !in_valid_ff || advance;

   rpn_stack u_stack (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .res   (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func       <= req_ch.func;
         in_item_ff.push_value <= req_ch.push_value;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_res_ff.status;
   assign rsp_ch.top_value   = out_res_ff.top_value;
   assign rsp_ch.top_valid   = out_res_ff.top_valid;
   assign rsp_ch.stack_depth = out_res_ff.stack_depth;
   assign rsp_ch.saturated   = out_res_ff.saturated;

endmodule
